// ----- rtl/core/i2csrb_pkg.sv -----
// ----------------------------------------------------------------------------
// i2csrb_pkg
// Shared types and constants of the i2c slave register buffer unit.
// ----------------------------------------------------------------------------
package i2csrb_pkg;

  // bus and local command codes
  localparam logic [1:0] CMD_START    = 2'd0;
  localparam logic [1:0] CMD_OVERFLOW = 2'd1;
  localparam logic [1:0] CMD_TX_WRITE = 2'd2;
  localparam logic [1:0] CMD_RX_READ  = 2'd3;

  // reset value of the slave address register
  localparam logic [6:0] OWN_ADDRESS_RESET = 7'd42;

  // store addresses are carried wide enough for the largest buffer
  localparam int unsigned ADDR_W = 9;
  typedef logic [ADDR_W-1:0] addr_t;

  // write request into one byte store
  typedef struct packed {
    logic       en;
    addr_t      addr;
    logic [7:0] data;
  } store_wr_t;

  // one result item
  typedef struct packed {
    logic [7:0] local_read_data;
    logic       go_idle;
    logic       single_bit;
    logic       drive_sda;
    logic [7:0] load_byte;
  } result_t;

endpackage

// ----- rtl/core/i2c_slave_register_buffer_unit.sv -----
// ----------------------------------------------------------------------------
// i2c_slave_register_buffer_unit
// Byte sequencer of an i2c slave with a register pointer, a receive buffer
// and a transmit buffer, fed with bus events and local buffer commands.
// ----------------------------------------------------------------------------
//  channel   dir  request content
//  s_axis    in   tuser: cmd; tdata: shift_byte, local_index, local_data
//  m_axis    out  tdata: load_byte, drive_sda, single_bit, go_idle,
//                 local_read_data
//  cfg       in   cfg_data_i: own_address
//
//  one request per cycle while m_axis does not stall; a result passes the
//  input register, then the result register
//  the buffer read ports are registered ahead of the request they serve,
//  with same-cycle writes forwarded
//  reset clears phase, pointer, buffer written flags and both channels
//  a stalled m_axis holds the input register; s_axis keeps flowing until it
//  is full
// ----------------------------------------------------------------------------
module i2c_slave_register_buffer_unit #(
  parameter int unsigned BUFFER_DEPTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // shift_byte, local_index, local_data, zero fill
  input  logic [1:0]  s_axis_tuser,   // cmd
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // load_byte, drive_sda, single_bit, go_idle,
                                      // local_read_data, zero fill
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [6:0]  cfg_data_i
);

  logic                  in_valid_q, in_valid_d;
  logic [1:0]            cmd_q;
  logic [7:0]            byte_q;
  logic [3:0]            idx_q;
  logic [7:0]            ldata_q;
  logic                  out_valid_q, out_valid_d;
  logic [23:0]           out_data_q;
  logic [6:0]            own_address_q;
  logic                  advance;
  logic                  accept;
  i2csrb_pkg::addr_t     rx_raddr;
  i2csrb_pkg::addr_t     tx_raddr;
  i2csrb_pkg::store_wr_t tx_wr;
  i2csrb_pkg::store_wr_t rx_wr;
  i2csrb_pkg::result_t   result;
  logic [7:0]            tx_rdata;
  logic [7:0]            rx_rdata;

  // handshake
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign in_valid_d    = accept || (in_valid_q && !advance);
  assign out_valid_d   = advance || (out_valid_q && !m_axis_tready);
  assign cfg_ready_o   = 1'b1;

  // receive buffer follows the index of the request held next cycle
  assign rx_raddr = accept ? i2csrb_pkg::ADDR_W'(s_axis_tdata[11:8])
                           : i2csrb_pkg::ADDR_W'(idx_q);

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q    <= 1'b0;
      out_valid_q   <= 1'b0;
      own_address_q <= i2csrb_pkg::OWN_ADDRESS_RESET;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i) begin
        own_address_q <= cfg_data_i;
      end
    end
  end

  // input and result payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q   <= s_axis_tuser;
      byte_q  <= s_axis_tdata[7:0];
      idx_q   <= s_axis_tdata[11:8];
      ldata_q <= s_axis_tdata[19:12];
    end
    if (advance) begin
      out_data_q <= {5'd0, result.local_read_data, result.go_idle, result.single_bit,
                     result.drive_sda, result.load_byte};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  i2csrb_seq #(
    .BUFFER_DEPTH(BUFFER_DEPTH)
  ) u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .fire_i       (advance),
    .cmd_i        (cmd_q),
    .shift_byte_i (byte_q),
    .local_index_i(idx_q),
    .local_data_i (ldata_q),
    .own_address_i(own_address_q),
    .tx_rdata_i   (tx_rdata),
    .rx_rdata_i   (rx_rdata),
    .tx_raddr_o   (tx_raddr),
    .tx_wr_o      (tx_wr),
    .rx_wr_o      (rx_wr),
    .result_o     (result)
  );

  i2csrb_store #(
    .BUFFER_DEPTH(BUFFER_DEPTH)
  ) u_tx_store (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .wr_i   (tx_wr),
    .raddr_i(tx_raddr),
    .rdata_o(tx_rdata)
  );

  i2csrb_store #(
    .BUFFER_DEPTH(BUFFER_DEPTH)
  ) u_rx_store (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .wr_i   (rx_wr),
    .raddr_i(rx_raddr),
    .rdata_o(rx_rdata)
  );

endmodule

// ----- rtl/core/i2csrb_store.sv -----
// ----------------------------------------------------------------------------
// i2csrb_store
// Byte store with one write port and one registered read port; entries read
// as zero until written, and a write in the read cycle is forwarded.
// ----------------------------------------------------------------------------
module i2csrb_store #(
  parameter int unsigned BUFFER_DEPTH = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  i2csrb_pkg::store_wr_t wr_i,
  input  i2csrb_pkg::addr_t   raddr_i,
  output logic [7:0]          rdata_o
);

  localparam int unsigned AW = $clog2(BUFFER_DEPTH);

  logic [7:0]              mem [BUFFER_DEPTH];
  logic [BUFFER_DEPTH-1:0] written_q;
  logic [7:0]              mem_rd_q;
  logic                    hit_q;
  logic [7:0]              fwd_q;
  logic                    ok_q;
  logic                    rd_in_range;
  logic [AW-1:0]           rd_idx;
  logic [AW-1:0]           wr_idx;

  assign rd_in_range = raddr_i < i2csrb_pkg::ADDR_W'(BUFFER_DEPTH);
  assign rd_idx      = raddr_i[AW-1:0];
  assign wr_idx      = wr_i.addr[AW-1:0];

  // storage array and raw read
  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_idx] <= wr_i.data;
    end
    mem_rd_q <= mem[rd_idx];
    fwd_q    <= wr_i.data;
  end

  // written flags and read qualifiers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      written_q <= '0;
      hit_q     <= 1'b0;
      ok_q      <= 1'b0;
    end else begin
      if (wr_i.en) begin
        written_q[wr_idx] <= 1'b1;
      end
      hit_q <= wr_i.en && (wr_i.addr == raddr_i);
      ok_q  <= rd_in_range && written_q[rd_idx];
    end
  end

  // forwarded write wins, unwritten entries read as zero
  assign rdata_o = hit_q ? fwd_q : (ok_q ? mem_rd_q : 8'd0);

endmodule

// ----- rtl/core/i2csrb_seq.sv -----
// ----------------------------------------------------------------------------
// i2csrb_seq
// Byte-level bus sequencer: phase, pointer and the result of one item.
// ----------------------------------------------------------------------------
module i2csrb_seq #(
  parameter int unsigned BUFFER_DEPTH = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  fire_i,
  input  logic [1:0]            cmd_i,
  input  logic [7:0]            shift_byte_i,
  input  logic [3:0]            local_index_i,
  input  logic [7:0]            local_data_i,
  input  logic [6:0]            own_address_i,
  input  logic [7:0]            tx_rdata_i,
  input  logic [7:0]            rx_rdata_i,
  output i2csrb_pkg::addr_t     tx_raddr_o,
  output i2csrb_pkg::store_wr_t tx_wr_o,
  output i2csrb_pkg::store_wr_t rx_wr_o,
  output i2csrb_pkg::result_t   result_o
);

  localparam int unsigned AW = $clog2(BUFFER_DEPTH);

  // phase codes
  localparam logic [2:0] PH_ADDRESS     = 3'd0;
  localparam logic [2:0] PH_SEND        = 3'd1;
  localparam logic [2:0] PH_ASK_REPLY   = 3'd2;
  localparam logic [2:0] PH_CHECK_REPLY = 3'd3;
  localparam logic [2:0] PH_ASK_DATA    = 3'd4;
  localparam logic [2:0] PH_TAKE_DATA   = 3'd5;

  logic [2:0]    phase_q, phase_d;
  logic          active_q, active_d;
  logic [AW-1:0] ptr_q, ptr_d;
  logic          pvalid_q, pvalid_d;
  logic [2:0]    ph;
  logic [AW:0]   ptr_inc;
  logic [AW-1:0] ptr_next;
  logic [AW-1:0] send_ptr;
  logic [AW-1:0] pos;
  logic          idx_ok;
  logic          addr_match;

  // pointer helpers
  assign ptr_inc    = {1'b0, ptr_q} + (AW+1)'(1);
  assign ptr_next   = (ptr_inc == (AW+1)'(BUFFER_DEPTH)) ? '0 : ptr_inc[AW-1:0];
  assign send_ptr   = pvalid_q ? ptr_q : '0;
  assign pos        = ({1'b0, shift_byte_i} < 9'(BUFFER_DEPTH)) ? shift_byte_i[AW-1:0] : '0;
  assign idx_ok     = {5'd0, local_index_i} < 9'(BUFFER_DEPTH);
  assign addr_match = (shift_byte_i == 8'd0) || (shift_byte_i[7:1] == own_address_i);

  // next state and result
  always_comb begin
    phase_d  = phase_q;
    active_d = active_q;
    ptr_d    = ptr_q;
    pvalid_d = pvalid_q;
    ph       = phase_q;
    result_o = '0;
    tx_wr_o  = '0;
    rx_wr_o  = '0;
    if (fire_i) begin
      unique case (cmd_i)
        i2csrb_pkg::CMD_START: begin
          phase_d  = PH_ADDRESS;
          active_d = 1'b1;
        end
        i2csrb_pkg::CMD_TX_WRITE: begin
          tx_wr_o.en   = idx_ok;
          tx_wr_o.addr = i2csrb_pkg::ADDR_W'(local_index_i);
          tx_wr_o.data = local_data_i;
        end
        i2csrb_pkg::CMD_RX_READ: begin
          result_o.local_read_data = rx_rdata_i;
        end
        default: begin
          if (!active_q) begin
            result_o.go_idle = 1'b1;
          end else if (phase_q == PH_CHECK_REPLY && shift_byte_i != 8'd0) begin
            // master nack ends the transmit
            active_d         = 1'b0;
            result_o.go_idle = 1'b1;
          end else begin
            if (phase_q == PH_CHECK_REPLY) begin
              ph = PH_SEND;
            end
            unique case (ph)
              PH_ADDRESS: begin
                if (addr_match) begin
                  if (shift_byte_i[0]) begin
                    phase_d = PH_SEND;
                  end else begin
                    phase_d  = PH_ASK_DATA;
                    pvalid_d = 1'b0;
                  end
                  result_o.drive_sda  = 1'b1;
                  result_o.single_bit = 1'b1;
                end else begin
                  active_d         = 1'b0;
                  result_o.go_idle = 1'b1;
                end
              end
              PH_SEND: begin
                // store read data already follows send_ptr
                pvalid_d           = 1'b1;
                ptr_d              = (send_ptr == ptr_q && pvalid_q) ? ptr_next :
                                     ((AW'(1) == AW'(BUFFER_DEPTH)) ? '0 : AW'(1));
                phase_d            = PH_ASK_REPLY;
                result_o.load_byte = tx_rdata_i;
                result_o.drive_sda = 1'b1;
              end
              PH_ASK_REPLY: begin
                phase_d             = PH_CHECK_REPLY;
                result_o.single_bit = 1'b1;
              end
              PH_ASK_DATA: begin
                phase_d = PH_TAKE_DATA;
              end
              PH_TAKE_DATA: begin
                if (!pvalid_q) begin
                  ptr_d    = pos;
                  pvalid_d = 1'b1;
                end else begin
                  rx_wr_o.en   = 1'b1;
                  rx_wr_o.addr = i2csrb_pkg::ADDR_W'(ptr_q);
                  rx_wr_o.data = shift_byte_i;
                  ptr_d        = ptr_next;
                end
                phase_d             = PH_ASK_DATA;
                result_o.drive_sda  = 1'b1;
                result_o.single_bit = 1'b1;
              end
              default: begin
                active_d         = 1'b0;
                phase_d          = PH_ADDRESS;
                result_o.go_idle = 1'b1;
              end
            endcase
          end
        end
      endcase
    end
  end

  // address of the next send, read ahead through the registered store port
  assign tx_raddr_o = pvalid_d ? i2csrb_pkg::ADDR_W'(ptr_d) : '0;

  // sequencer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_ADDRESS;
      active_q <= 1'b0;
      ptr_q    <= '0;
      pvalid_q <= 1'b0;
    end else begin
      phase_q  <= phase_d;
      active_q <= active_d;
      ptr_q    <= ptr_d;
      pvalid_q <= pvalid_d;
    end
  end

endmodule
